FILE: rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned NUM_W  = 33;
  localparam int unsigned DEN_W  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/rau_in_if.sv
// Operand channel: operation code and two signed fractions.
interface rau_in_if #(
  parameter int unsigned OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  rau_pkg::func_e                  func;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: rtl/rau_out_if.sv
// Result channel: one result fraction and an error flag.
interface rau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rau_pkg::NUM_W-1:0] res_num;
  logic signed [rau_pkg::DEN_W-1:0] res_den;
  logic                             invalid;

  modport source (output valid, res_num, res_den, invalid, input ready);
  modport sink   (input valid, res_num, res_den, invalid, output ready);
endinterface

FILE: rtl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
  parameter int unsigned WIDTH = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH-1:0]   dividend_i,
  input  logic [WIDTH-1:0]   divisor_i,
  output rau_pkg::div_stat_t stat_o,
  output logic [WIDTH-1:0]   quo_o,
  output logic [WIDTH-1:0]   rem_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;
  logic           fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  // Load on start, then shift one bit per cycle
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

FILE: rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: add, subtract, multiply, divide of signed fractions.
// Multiply and divide form the product pairs and skip the reduction; operand errors go straight to the result.
// Add and subtract also reduce the result by its gcd, found with Euclid steps on the shared bit-serial
// divider of width IW = min(2 * OPERAND_WIDTH + 1, 64).
// One item in flight; a finished result waits in the output register while the next starts.
// Reset clears the sequencer, the divider control and the output valid flag.
module rational_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rau_in_if.sink    in_chan,
  rau_out_if.source out_chan
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned IW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_MUL      = 11'b000_0000_0010,
    S_SUM      = 11'b000_0000_0100,
    S_INIT     = 11'b000_0000_1000,
    S_GCD_GO   = 11'b000_0001_0000,
    S_GCD_WAIT = 11'b000_0010_0000,
    S_QN_GO    = 11'b000_0100_0000,
    S_QN_WAIT  = 11'b000_1000_0000,
    S_QD_GO    = 11'b001_0000_0000,
    S_QD_WAIT  = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  function automatic logic [IW-1:0] mag(input logic [IW-1:0] v);
    return v[IW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [IW-1:0] apply_sign(input logic [IW-1:0] m, input logic neg);
    return neg ? (~m + 1'b1) : m;
  endfunction

  state_e state_q, state_d;
  logic [1:0] mcnt_q, mcnt_d;
  logic       out_valid_q, out_valid_d;

  rau_pkg::func_e func_q, func_d;
  logic signed [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic        bad_q, bad_d;
  logic [IW-1:0] num_q, num_d, den_q, den_d, p_q, p_d;
  logic [IW-1:0] gx_q, gx_d, gy_q, gy_d, g_q, g_d;
  logic signed [rau_pkg::NUM_W-1:0] res_num_q, res_num_d;
  logic signed [rau_pkg::DEN_W-1:0] res_den_q, res_den_d;
  logic        res_inv_q, res_inv_d;

  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] prod;
  logic signed [IW-1:0]  prod_ext;
  logic signed [63:0]    num_wide;
  logic signed [63:0]    den_wide;
  logic                  is_addsub;
  logic                  in_bad;

  logic          div_start;
  logic [IW-1:0] div_dividend, div_divisor, div_quo, div_rem;
  rau_pkg::div_stat_t div_stat;

  // Shared divider for Euclid remainders and the final reduction
  rau_div #(.WIDTH(IW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign is_addsub = (func_q == rau_pkg::FUNC_ADD) || (func_q == rau_pkg::FUNC_SUB);
  assign in_bad    = (in_chan.a_den == '0) || (in_chan.b_den == '0) ||
                     ((in_chan.func == rau_pkg::FUNC_DIV) && (in_chan.b_num == '0));

  // Pick the operand pair for the shared multiplier
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (mcnt_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = (func_q == rau_pkg::FUNC_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_a = is_addsub ? bn_q : ad_q;
        mul_b = is_addsub ? ad_q : ((func_q == rau_pkg::FUNC_MUL) ? bd_q : bn_q);
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = IW'(prod);

  // Divider operands follow the issuing state
  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag(gx_q);
    div_divisor  = mag(gy_q);
    priority case (1'b1)
      (state_q == S_GCD_GO): begin
        div_start = 1'b1;
      end
      (state_q == S_QN_GO): begin
        div_start    = 1'b1;
        div_dividend = mag(num_q);
        div_divisor  = mag(g_q);
      end
      (state_q == S_QD_GO): begin
        div_start    = 1'b1;
        div_dividend = mag(den_q);
        div_divisor  = mag(g_q);
      end
      default: ;
    endcase
  end

  assign num_wide = 64'(signed'(num_q));
  assign den_wide = 64'(signed'(den_q));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mcnt_d      = mcnt_q;
    out_valid_d = out_valid_q;
    func_d      = func_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    bad_d       = bad_q;
    num_d       = num_q;
    den_d       = den_q;
    p_d         = p_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    g_d         = g_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    res_inv_d   = res_inv_q;

    // Drop the result beat once taken
    if (out_valid_q && out_chan.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_chan.valid) begin
          func_d = in_chan.func;
          an_d   = in_chan.a_num;
          ad_d   = in_chan.a_den;
          bn_d   = in_chan.b_num;
          bd_d   = in_chan.b_den;
          bad_d  = in_bad;
          mcnt_d = 2'd0;
          if (in_bad) begin
            num_d   = '0;
            den_d   = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        mcnt_d = mcnt_q + 2'd1;
        unique case (mcnt_q)
          2'd0: num_d = prod_ext;
          2'd1: begin
            if (is_addsub) begin
              p_d = prod_ext;
            end else begin
              den_d   = prod_ext;
              state_d = S_DONE;
            end
          end
          default: begin
            den_d   = prod_ext;
            state_d = S_SUM;
          end
        endcase
      end
      S_SUM: begin
        num_d   = (func_q == rau_pkg::FUNC_ADD) ? (num_q + p_q) : (num_q - p_q);
        state_d = S_INIT;
      end
      S_INIT: begin
        // A zero numerator has the denominator as its divisor
        if (num_q == '0) begin
          g_d     = den_q;
          state_d = S_QN_GO;
        end else begin
          gx_d    = num_q;
          gy_d    = den_q;
          state_d = S_GCD_GO;
        end
      end
      S_GCD_GO: state_d = S_GCD_WAIT;
      S_GCD_WAIT: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            g_d     = gy_q;
            state_d = S_QN_GO;
          end else begin
            gx_d    = gy_q;
            gy_d    = apply_sign(div_rem, gx_q[IW-1]);
            state_d = S_GCD_GO;
          end
        end
      end
      S_QN_GO: state_d = S_QN_WAIT;
      S_QN_WAIT: begin
        if (div_stat.done) begin
          num_d   = apply_sign(div_quo, num_q[IW-1] ^ g_q[IW-1]);
          state_d = S_QD_GO;
        end
      end
      S_QD_GO: state_d = S_QD_WAIT;
      S_QD_WAIT: begin
        if (div_stat.done) begin
          den_d   = apply_sign(div_quo, den_q[IW-1] ^ g_q[IW-1]);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_chan.ready) begin
          res_num_d   = num_wide[rau_pkg::NUM_W-1:0];
          res_den_d   = den_wide[rau_pkg::DEN_W-1:0];
          res_inv_d   = bad_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    bad_q     <= bad_d;
    num_q     <= num_d;
    den_q     <= den_d;
    p_q       <= p_d;
    gx_q      <= gx_d;
    gy_q      <= gy_d;
    g_q       <= g_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_inv_q <= res_inv_d;
  end

  assign in_chan.ready    = (state_q == S_IDLE);
  assign out_chan.valid   = out_valid_q;
  assign out_chan.res_num = res_num_q;
  assign out_chan.res_den = res_den_q;
  assign out_chan.invalid = res_inv_q;

  // An error beat carries 0/0
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid && out_chan.invalid |-> (out_chan.res_num == '0) && (out_chan.res_den == '0))
    else $error("error result is not 0/0");

  // The divider is only started when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // Euclid never divides by zero
  a_gcd_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD_GO) |-> (gy_q != '0))
    else $error("zero divisor in gcd step");

  // A new beat is taken only with the divider idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan.ready |-> !div_stat.busy && !div_stat.done)
    else $error("input ready while divider active");

endmodule

FILE: tb/rational_arithmetic_unit_top_tb.sv
// Testbench for the rational arithmetic unit: directed table, then random beats vs. predictor.
module rational_arithmetic_unit_top_tb;

  localparam int unsigned OPW          = 16;
  localparam int          RANDOM_BEATS = 1827;
  localparam int          MAX_GAP      = 12;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 2500;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 64;

  typedef struct {
    rau_pkg::func_e        func;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
  } operands_t;

  typedef struct {
    logic signed [rau_pkg::NUM_W-1:0] res_num;
    logic signed [rau_pkg::DEN_W-1:0] res_den;
    logic                             invalid;
  } fraction_t;

  typedef struct {
    operands_t ops;
    bit        typed;
    fraction_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rau_in_if #(.OPERAND_WIDTH(OPW)) in_chan ();
  rau_out_if                       out_chan ();

  rational_arithmetic_unit_top #(.OPERAND_WIDTH(OPW)) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fraction_t pending_fractions[$];
  stim_row_t directed_rows[$];
  int        mismatch_count  = 0;
  int        results_checked = 0;
  int        op_count[4]     = '{0, 0, 0, 0};
  int        error_beats     = 0;
  int        stall_cycles    = 0;
  bit        hold_off_active = 1'b0;

  always #5 clk_i = ~clk_i;

  // Euclid with truncating remainder; the last nonzero divisor keeps its sign
  function automatic longint trunc_gcd(longint x, longint y);
    longint r;
    if (x == 0) return y;
    if (y == 0) return x;
    r = x % y;
    while (r != 0) begin
      x = y;
      y = r;
      r = x % y;
    end
    return y;
  endfunction

  // Work out the result fraction of one operand beat
  function automatic fraction_t compute_fraction(operands_t b);
    longint    an, ad, bn, bd, num, den, g;
    fraction_t f;
    an  = b.a_num;
    ad  = b.a_den;
    bn  = b.b_num;
    bd  = b.b_den;
    num = 0;
    den = 0;
    f.invalid = (ad == 0) || (bd == 0) || (b.func == rau_pkg::FUNC_DIV && bn == 0);
    if (!f.invalid) begin
      case (b.func)
        rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
          num = (b.func == rau_pkg::FUNC_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
          den = ad * bd;
          g   = trunc_gcd(num, den);
          if (g != 0) begin
            num = num / g;
            den = den / g;
          end
        end
        rau_pkg::FUNC_MUL: begin
          num = an * bn;
          den = ad * bd;
        end
        default: begin
          num = an * bd;
          den = ad * bn;
        end
      endcase
    end
    f.res_num = num[rau_pkg::NUM_W-1:0];
    f.res_den = den[rau_pkg::DEN_W-1:0];
    return f;
  endfunction

  task automatic add_row(rau_pkg::func_e fn, int an, int ad, int bn, int bd,
                         bit typed = 1'b0, longint wn = 0, longint wd = 0, bit winv = 1'b0);
    stim_row_t r;
    r.ops.func      = fn;
    r.ops.a_num     = an[OPW-1:0];
    r.ops.a_den     = ad[OPW-1:0];
    r.ops.b_num     = bn[OPW-1:0];
    r.ops.b_den     = bd[OPW-1:0];
    r.typed         = typed;
    r.want.res_num  = wn[rau_pkg::NUM_W-1:0];
    r.want.res_den  = wd[rau_pkg::DEN_W-1:0];
    r.want.invalid  = winv;
    directed_rows.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("ERROR result %0d: %s is %0d, expected %0d at %0t",
             results_checked, field, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offer one beat after a gap; record its result once the beat is taken
  task automatic drive_operands(operands_t b, int gap, fraction_t want);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.func  <= b.func;
    in_chan.a_num <= b.a_num;
    in_chan.a_den <= b.a_den;
    in_chan.b_num <= b.b_num;
    in_chan.b_den <= b.b_den;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    pending_fractions.push_back(want);
    op_count[b.func]++;
    if (want.invalid) error_beats++;
    @(negedge clk_i);
  endtask

  // Mostly small operands; some full-width and some picked from the extremes
  function automatic logic signed [OPW-1:0] draw_operand(int size_class);
    logic signed [OPW-1:0] v;
    case (size_class)
      0: v = OPW'($urandom_range(0, 40) - 20);
      1: v = OPW'($urandom());
      default: begin
        case ($urandom_range(0, 5))
          0:       v = {1'b1, {(OPW-1){1'b0}}};
          1:       v = {1'b0, {(OPW-1){1'b1}}};
          2:       v = '0;
          3:       v = OPW'(1);
          4:       v = '1;
          default: v = OPW'($urandom());
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int draw_gap(int idx);
    if (hold_off_active || ((idx / 96) % 5) == 3) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Stall watchdog: count cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR no beat for %0d cycles", STALL_LIMIT);
        $display("FAIL rational_arithmetic_unit_top");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off, compare each beat
  initial begin
    fraction_t want;
    int        gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = (((results_checked / 128) % 4) == 2) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_chan.valid) @(posedge clk_i);
      if (pending_fractions.size() == 0) begin
        report_mismatch("unexpected beat res_num", out_chan.res_num, 0);
      end else begin
        want = pending_fractions.pop_front();
        if (out_chan.res_num !== want.res_num)
          report_mismatch("res_num", out_chan.res_num, want.res_num);
        if (out_chan.res_den !== want.res_den)
          report_mismatch("res_den", out_chan.res_den, want.res_den);
        if (out_chan.invalid !== want.invalid)
          report_mismatch("invalid", out_chan.invalid, want.invalid);
      end
      results_checked++;
      @(negedge clk_i);
      // Hold off long enough for the block to back up into its input
      if (results_checked == HOLD_AT) begin
        hold_off_active = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_active = 1'b0;
      end
    end
  end

  // Operand side: reset, directed table, random beats, drain
  initial begin
    operands_t b;
    stim_row_t row;
    int        size_class;
    int        pick;

    rst_ni         = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.func   = rau_pkg::FUNC_ADD;
    in_chan.a_num  = '0;
    in_chan.a_den  = '0;
    in_chan.b_num  = '0;
    in_chan.b_den  = '0;
    out_chan.ready = 1'b0;

    // Plain cases, sign flips from the gcd and cancellation to zero
    add_row(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
    add_row(rau_pkg::FUNC_SUB, 3, 4, 3, 4, 1'b1, 0, 1, 1'b0);
    add_row(rau_pkg::FUNC_ADD, 5, 7, -5, 7, 1'b1, 0, 1, 1'b0);
    add_row(rau_pkg::FUNC_MUL, 2, 3, 5, 7);
    add_row(rau_pkg::FUNC_DIV, 2, 3, 5, 7);
    add_row(rau_pkg::FUNC_ADD, 1, 2, 1, -3);
    add_row(rau_pkg::FUNC_SUB, -7, 9, 4, -15);
    add_row(rau_pkg::FUNC_ADD, 0, -1, 0, -1, 1'b1, 0, 1, 1'b0);
    add_row(rau_pkg::FUNC_SUB, 0, -5, 0, 3, 1'b1, 0, 1, 1'b0);
    add_row(rau_pkg::FUNC_MUL, 0, 4, 5, 6, 1'b1, 0, 24, 1'b0);
    // Zero denominators and zero divisor
    add_row(rau_pkg::FUNC_ADD, 1, 0, 1, 1, 1'b1, 0, 0, 1'b1);
    add_row(rau_pkg::FUNC_SUB, 1, 1, 1, 0, 1'b1, 0, 0, 1'b1);
    add_row(rau_pkg::FUNC_MUL, 3, 0, 5, 0, 1'b1, 0, 0, 1'b1);
    add_row(rau_pkg::FUNC_DIV, 3, 4, 0, 5, 1'b1, 0, 0, 1'b1);
    add_row(rau_pkg::FUNC_DIV, 3, 4, 5, 0, 1'b1, 0, 0, 1'b1);
    // Field extremes
    add_row(rau_pkg::FUNC_MUL, -32768, -32768, -32768, -32768,
            1'b1, 1073741824, 1073741824, 1'b0);
    add_row(rau_pkg::FUNC_MUL, 32767, 1, 32767, 1, 1'b1, 1073676289, 1, 1'b0);
    add_row(rau_pkg::FUNC_DIV, -32768, 1, 1, -32768, 1'b1, 1073741824, 1, 1'b0);
    add_row(rau_pkg::FUNC_MUL, -32768, 32767, 32767, -32768,
            1'b1, -1073709056, -1073709056, 1'b0);
    add_row(rau_pkg::FUNC_ADD, 32767, -32768, 32767, -32767);
    add_row(rau_pkg::FUNC_SUB, -32768, 32767, 32767, -32768);
    add_row(rau_pkg::FUNC_ADD, -32768, 1, -32768, 1);
    add_row(rau_pkg::FUNC_DIV, -1, -1, -1, -1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      drive_operands(row.ops, $urandom_range(0, MAX_GAP),
                     row.typed ? row.want : compute_fraction(row.ops));
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // Drain the block once midway before offering more
      if (i == RANDOM_BEATS / 2) begin
        in_chan.valid <= 1'b0;
        wait (pending_fractions.size() == 0);
        @(negedge clk_i);
      end
      pick       = $urandom_range(0, 99);
      size_class = (pick < 60) ? 0 : (pick < 85) ? 2 : 1;
      b.func     = rau_pkg::func_e'($urandom_range(0, 3));
      b.a_num    = draw_operand(size_class);
      b.a_den    = draw_operand(size_class);
      b.b_num    = draw_operand(size_class);
      b.b_den    = draw_operand(size_class);
      drive_operands(b, draw_gap(i), compute_fraction(b));
    end
    in_chan.valid <= 1'b0;

    wait (pending_fractions.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d operand beats: %0d add, %0d sub, %0d mul, %0d div, %0d invalid.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3], error_beats);
    $display("Checked %0d result beats, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS rational_arithmetic_unit_top");
    end else begin
      $display("FAIL rational_arithmetic_unit_top");
    end
    $finish;
  end

endmodule

FILE: rational_arithmetic_unit_top.f
rtl/rau_pkg.sv
rtl/rau_in_if.sv
rtl/rau_out_if.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit_top.sv
tb/rational_arithmetic_unit_top_tb.sv
